[rtl/prm_pkg.sv]
// Shared widths, register indexes and status codes for the pulse rate meter.
package prm_pkg;

  // Fixed field widths of the stream and configuration items
  localparam int COUNT_IN_W  = 32;
  localparam int STAMP_IN_W  = 48;
  localparam int STAMP_EXT_W = 64;
  localparam int MOD_W       = 33;
  localparam int REG_W       = 32;
  localparam int RATE_W      = 48;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = COUNT_IN_W + STAMP_IN_W;

  // Delta holds reading plus modulus, product is delta times scale
  localparam int DELTA_W = MOD_W + 1;
  localparam int PROD_W  = DELTA_W + REG_W;

  // Parameter defaults
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int STAMP_WIDTH_DEF = 48;
  localparam int FRAC_BITS_DEF   = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DELTA     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_HELD         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_UPDATED      = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO_ELAPSED = 2'd2;

  // Top level control states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CHECK = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

endpackage

[rtl/pulse_rate_meter.sv]
// Pulse rate meter: counter delta with rollover, rate = delta * scale / elapsed.
// Items with a held rate or zero elapsed time go from the check state straight to
// the final state; an update also passes the bit-serial multiplier and the divider,
// and the divider finishes at once when the quotient saturates.
// One item at a time; the next item is accepted the cycle after the result is
// loaded, and an output stall holds the block until the output register is free.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst, synchronous): stored count, stamp and rate cleared, registers at defaults.
module pulse_rate_meter #(
  parameter int COUNT_WIDTH = prm_pkg::COUNT_WIDTH_DEF,
  parameter int STAMP_WIDTH = prm_pkg::STAMP_WIDTH_DEF,
  parameter int FRAC_BITS   = prm_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [prm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prm_pkg::MOD_W-1:0]      cfg_data,
  // input stream
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [prm_pkg::IN_DATA_W-1:0]  s_tdata,   // counter_value[31:0], time_stamp[79:32]
  // result stream
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [prm_pkg::RATE_W-1:0]     m_tdata,   // rate_value[47:0]
  output logic [prm_pkg::STATUS_W-1:0]   m_tuser    // status[1:0]
);
  import prm_pkg::*;

  state_t state;

  logic [MOD_W-1:0]        count_modulus;
  logic [REG_W-1:0]        min_delta;
  logic [REG_W-1:0]        rate_scale;

  logic [COUNT_WIDTH-1:0]  previous_count;
  logic [STAMP_WIDTH-1:0]  previous_stamp;
  logic [RATE_W-1:0]       held_rate;

  logic [COUNT_WIDTH-1:0]  cv;
  logic [STAMP_WIDTH-1:0]  ts;
  logic [DELTA_W-1:0]      delta;
  logic [STAMP_WIDTH-1:0]  elapsed;
  logic [STATUS_W-1:0]     status;

  logic [STAMP_EXT_W-1:0]  ts_in_ext;
  logic [DELTA_W-1:0]      cv_ext;
  logic [DELTA_W-1:0]      pc_ext;
  logic [DELTA_W-1:0]      wrap_sum;
  logic                    gt;
  logic                    qualifies;
  logic [DELTA_W-1:0]      delta_next;
  logic [STAMP_WIDTH-1:0]  elapsed_next;
  logic                    big;

  logic                    mul_start;
  logic                    mul_done;
  logic [PROD_W-1:0]       product;
  logic                    div_start;
  logic                    div_done;
  logic [RATE_W-1:0]       quotient;
  logic                    out_free;
  logic                    s_accept;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  assign ts_in_ext = STAMP_EXT_W'(s_tdata[COUNT_IN_W +: STAMP_IN_W]);

  // Delta with rollover; an equal reading counts as one full wrap
  assign cv_ext     = DELTA_W'(cv);
  assign pc_ext     = DELTA_W'(previous_count);
  assign wrap_sum   = cv_ext + DELTA_W'(count_modulus);
  assign gt         = (cv > previous_count);
  assign qualifies  = gt || (wrap_sum >= pc_ext);
  assign delta_next = gt ? (cv_ext - pc_ext) : (wrap_sum - pc_ext);
  assign big        = qualifies && (delta_next > DELTA_W'(min_delta));
  assign elapsed_next = ts - previous_stamp;

  assign mul_start = (state == ST_CHECK) && big && (elapsed_next != '0);
  assign div_start = (state == ST_MUL) && mul_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_modulus <= MOD_W'(64'h1_0000_0000);
      min_delta     <= '0;
      rate_scale    <= REG_W'(64'd1 << FRAC_BITS);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COUNT_MODULUS: count_modulus <= cfg_data;
        REG_MIN_DELTA:     min_delta     <= cfg_data[REG_W-1:0];
        REG_RATE_SCALE:    rate_scale    <= cfg_data[REG_W-1:0];
        default:           ;
      endcase
    end
  end

  // Control sequencer, stored state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      previous_count <= '0;
      previous_stamp <= '0;
      held_rate      <= '0;
      m_tvalid       <= 1'b0;
    end else begin
      // load a new result, else drop the one just taken
      if ((state == ST_FIN) && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= mul_start ? ST_MUL : ST_FIN;
        end
        ST_MUL: begin
          if (mul_done) begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            held_rate      <= quotient;
            previous_count <= cv;
            previous_stamp <= ts;
            state          <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Item payload and intermediate values
  always_ff @(posedge clk) begin
    if (s_accept) begin
      cv <= s_tdata[COUNT_WIDTH-1:0];
      ts <= ts_in_ext[STAMP_WIDTH-1:0];
    end
    if (state == ST_CHECK) begin
      delta   <= delta_next;
      elapsed <= elapsed_next;
      if (!big) begin
        status <= STAT_HELD;
      end else if (elapsed_next == '0) begin
        status <= STAT_ZERO_ELAPSED;
      end else begin
        status <= STAT_UPDATED;
      end
    end
    if ((state == ST_FIN) && out_free) begin
      m_tdata <= held_rate;
      m_tuser <= status;
    end
  end

  // Multiplier reads delta from the cycle after start onward
  prm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .delta   (delta),
    .scale   (rate_scale),
    .done    (mul_done),
    .product (product)
  );

  prm_div #(
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

[rtl/prm_mul.sv]
// Bit-serial shift-add multiplier: delta times rate scale, one scale bit per cycle.
module prm_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [prm_pkg::DELTA_W-1:0]  delta,
  input  logic [prm_pkg::REG_W-1:0]    scale,
  output logic                         done,
  output logic [prm_pkg::PROD_W-1:0]   product
);
  import prm_pkg::*;

  localparam int CNT_W = $clog2(REG_W);

  logic [PROD_W-1:0]  acc;
  logic [CNT_W-1:0]   cnt;
  logic               busy;
  logic [DELTA_W:0]   psum;

  // Scale bits sit in the low half and shift out as the product shifts in
  assign psum = {1'b0, acc[PROD_W-1:REG_W]} + (acc[0] ? {1'b0, delta} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(REG_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Accumulator datapath
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= {{DELTA_W{1'b0}}, scale};
    end else if (busy) begin
      acc <= {psum, acc[REG_W-1:1]};
    end
  end

  assign product = acc;

endmodule

[rtl/prm_div.sv]
// Restoring bit-serial divider with up-front saturation check on the quotient.
module prm_div #(
  parameter int STAMP_WIDTH = prm_pkg::STAMP_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [prm_pkg::PROD_W-1:0]  dividend,
  input  logic [STAMP_WIDTH-1:0]      divisor,
  output logic                        done,
  output logic [prm_pkg::RATE_W-1:0]  quotient
);
  import prm_pkg::*;

  localparam int HI_W  = PROD_W - RATE_W;
  localparam int CMP_W = (STAMP_WIDTH > HI_W) ? STAMP_WIDTH : HI_W;
  localparam int CNT_W = $clog2(RATE_W);

  logic [STAMP_WIDTH-1:0] rem;
  logic [RATE_W-1:0]      dq;
  logic [CNT_W-1:0]       cnt;
  logic                   busy;
  logic [CMP_W-1:0]       hi_ext;
  logic [CMP_W-1:0]       div_ext;
  logic [STAMP_WIDTH:0]   trial;
  logic [STAMP_WIDTH:0]   diff;
  logic                   ge;

  assign hi_ext  = CMP_W'(dividend[PROD_W-1:RATE_W]);
  assign div_ext = CMP_W'(divisor);

  // One quotient bit per cycle; dividend bits leave dq as quotient bits enter
  assign trial = {rem, dq[RATE_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (hi_ext >= div_ext) begin
          // quotient would not fit in the rate width
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
          cnt  <= CNT_W'(RATE_W - 1);
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= hi_ext[STAMP_WIDTH-1:0];
      dq  <= (hi_ext >= div_ext) ? {RATE_W{1'b1}} : dividend[RATE_W-1:0];
    end else if (busy) begin
      rem <= ge ? diff[STAMP_WIDTH-1:0] : trial[STAMP_WIDTH-1:0];
      dq  <= {dq[RATE_W-2:0], ge};
    end
  end

  assign quotient = dq;

endmodule
